@@ hw/rtl/tes_pkg.sv @@
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants of the timestamped event scheduler
// Sizes of the event store and the command/status bundles between control
// and datapath.
// ----------------------------------------------------------------------------
package tes_pkg;

	localparam int CAPACITY  = 32;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int TIME_W    = 48;
	localparam int PAY_W     = 24;
	localparam int OFF_W     = 13;
	localparam int LEN_W     = 14;
	localparam int MAX_WINDOW = 8192;

	localparam logic KIND_SCHEDULE = 1'b0;
	localparam logic KIND_COLLECT  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_SHIFT,
		ST_PUT,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;       // capture input item
		logic find_step;  // issue memory read of the entry below pos
		logic shift_step; // move that entry up one slot
		logic put;        // write new event, bump count
		logic scan_read;  // issue memory read at scan index
		logic scan_eval;  // evaluate read data, keep or emit
		logic done_fin;   // finish collect: commit count
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic full;
		logic find_done;  // insertion slot is at the bottom
		logic shift_done; // entry below is not later than the new one
		logic scan_done;
		logic hit;        // evaluated entry lies in the window
		logic any_hit;    // a hit is held for output
	} sts_t;

endpackage

@@ hw/rtl/timestamped_event_scheduler.sv @@
// ----------------------------------------------------------------------------
// timestamped_event_scheduler: sorted store of timestamped events
// Schedule items insert an event in time order; collect items remove and
// return every event in a sample window, in time order, with its offset.
//
// Input channel: kind, payload, timestamp, window_start, window_length with
// in_valid/in_ready. One item is worked at a time; in_ready is high only
// when the sequencer is idle and the output register is not stalled.
// Output channel: has_event, event_payload, event_offset, accepted, last
// with out_valid/out_ready, from a single output register.
// Schedule: each stored entry later than the new timestamp is read, then
// moved up one slot (one memory port); then the new event is written and
// the result loaded. A full store skips the walk and loads the result.
// Collect: each stored entry is read, then kept in the store or emitted. Each
// hit is held until the next hit or the end of the scan, so the final event
// carries last; a collect that finds nothing gives one empty result.
// The next input transfer can follow the cycle after the final result loads.
// Reset clears the entry count and the sequencer; store contents are not
// cleared. A stalled receiver holds the scan at the next hit or at the end.
// ----------------------------------------------------------------------------
module timestamped_event_scheduler import tes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [PAY_W-1:0]  payload,
	input  logic [TIME_W-1:0] timestamp,
	input  logic [TIME_W-1:0] window_start,
	input  logic [LEN_W-1:0]  window_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              has_event,
	output logic [PAY_W-1:0]  event_payload,
	output logic [OFF_W-1:0]  event_offset,
	output logic              accepted,
	output logic              last
);

	cmd_t cmd;
	sts_t sts;
	logic [PAY_W-1:0] res_payload;
	logic [OFF_W-1:0] res_offset;
	logic res_accepted, res_has, res_last, res_load;

	tes_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .kind, .payload, .timestamp,
		.window_start, .window_length, .res_payload, .res_offset, .res_accepted
	);

	tes_control u_ctl (
		.clk, .arst_n, .in_valid, .in_ready, .out_busy(out_valid && !out_ready),
		.sts, .cmd, .res_has, .res_last, .res_load
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (res_load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			has_event     <= res_has;
			event_payload <= res_has ? res_payload : '0;
			event_offset  <= res_has ? res_offset : '0;
			accepted      <= res_has ? 1'b0 : res_accepted;
			last          <= res_last;
		end
	end

endmodule

@@ hw/rtl/tes_datapath.sv @@
// ----------------------------------------------------------------------------
// tes_datapath: event store and window logic
// Sorted store in two memories, an insertion walker, a compacting scan and
// a hold register for the latest hit.
// ----------------------------------------------------------------------------
module tes_datapath import tes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              kind,
	input  logic [PAY_W-1:0]  payload,
	input  logic [TIME_W-1:0] timestamp,
	input  logic [TIME_W-1:0] window_start,
	input  logic [LEN_W-1:0]  window_length,
	output logic [PAY_W-1:0]  res_payload,
	output logic [OFF_W-1:0]  res_offset,
	output logic              res_accepted
);

	logic [TIME_W-1:0] time_mem [CAPACITY];
	logic [PAY_W-1:0]  pay_mem  [CAPACITY];

	logic              kind_q;
	logic              acc_q;
	logic [PAY_W-1:0]  pay_q;
	logic [TIME_W-1:0] ts_q;
	logic [TIME_W-1:0] wstart_q;
	logic [TIME_W:0]   wend_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  pos_q;   // insertion walker / scan read index
	logic [CNT_W-1:0]  wr_q;    // compaction write index
	logic              any_q;
	logic [TIME_W-1:0] rd_time_q;
	logic [PAY_W-1:0]  rd_pay_q;
	logic [PAY_W-1:0]  hold_pay_q;
	logic [OFF_W-1:0]  hold_offset_q;
	logic              hit;
	logic [LEN_W-1:0]  len_sat;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic              we;
	logic [TIME_W-1:0] wr_time;
	logic [PAY_W-1:0]  wr_pay;

	assign len_sat = (window_length > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) :
		window_length;

	// read address: insertion looks at pos-1; scan reads pos
	always_comb begin
		if (cmd.scan_read)
			rd_addr = pos_q[IDX_W-1:0];
		else
			rd_addr = IDX_W'(pos_q - CNT_W'(1));
	end

	// read data stays put until the next read, so a stalled scan keeps it
	always_ff @(posedge clk) begin
		if (cmd.find_step || cmd.scan_read) begin
			rd_time_q <= time_mem[rd_addr];
			rd_pay_q  <= pay_mem[rd_addr];
		end
	end

	assign hit = (rd_time_q >= wstart_q) && ({1'b0, rd_time_q} < wend_q);

	always_comb begin
		we      = 1'b0;
		wr_addr = pos_q[IDX_W-1:0];
		wr_time = rd_time_q;
		wr_pay  = rd_pay_q;
		if (cmd.shift_step) begin
			we = 1'b1;
		end else if (cmd.put) begin
			we      = 1'b1;
			wr_time = ts_q;
			wr_pay  = pay_q;
		end else if (cmd.scan_eval && !hit) begin
			we      = 1'b1;
			wr_addr = wr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[wr_addr] <= wr_time;
			pay_mem[wr_addr]  <= wr_pay;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			acc_q    <= (kind == KIND_SCHEDULE) && (count_q != CNT_W'(CAPACITY));
			pay_q    <= payload;
			ts_q     <= timestamp;
			wstart_q <= window_start;
			wend_q   <= {1'b0, window_start} + (TIME_W+1)'(len_sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			wr_q    <= '0;
			any_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				pos_q <= (kind == KIND_SCHEDULE) ? count_q : '0;
				wr_q  <= '0;
				any_q <= 1'b0;
			end
			if (cmd.shift_step)
				pos_q <= pos_q - CNT_W'(1);
			if (cmd.put)
				count_q <= count_q + CNT_W'(1);
			if (cmd.scan_read)
				pos_q <= pos_q + CNT_W'(1);
			if (cmd.scan_eval) begin
				if (hit)
					any_q <= 1'b1;
				else
					wr_q <= wr_q + CNT_W'(1);
			end
			if (cmd.done_fin)
				count_q <= wr_q;
		end
	end

	// latest hit waits here until the next hit or the end of the scan
	always_ff @(posedge clk) begin
		if (cmd.scan_eval && hit) begin
			hold_pay_q    <= rd_pay_q;
			hold_offset_q <= OFF_W'(rd_time_q - wstart_q);
		end
	end

	assign res_payload  = hold_pay_q;
	assign res_offset   = hold_offset_q;
	assign res_accepted = acc_q;

	assign sts.kind       = kind_q;
	assign sts.full       = (count_q == CNT_W'(CAPACITY));
	assign sts.find_done  = (pos_q == '0);
	assign sts.shift_done = !(rd_time_q > ts_q);
	assign sts.scan_done  = (pos_q == count_q);
	assign sts.hit        = hit;
	assign sts.any_hit    = any_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY)) else $error("count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= pos_q || kind_q == KIND_SCHEDULE) else $error("compaction ahead of scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |=> count_q == $past(count_q) + CNT_W'(1)) else $error("put lost");

endmodule

@@ hw/rtl/tes_control.sv @@
// ----------------------------------------------------------------------------
// tes_control: sequencer of the timestamped event scheduler
// Walks the schedule and collect sequences and drives the output register.
// ----------------------------------------------------------------------------
module tes_control import tes_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  logic   out_busy,    // output register still holds a result
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   res_has,
	output logic   res_last,
	output logic   res_load
);

	state_t state_q, state_d;
	logic   pend_q; // scan read data waiting for evaluation
	logic   emit_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= cmd.scan_read || (pend_q && !cmd.scan_eval);
		end
	end

	// a new hit must push the held one out first
	assign emit_blocked = sts.hit && sts.any_hit && out_busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !out_busy)
					state_d = ST_FIND;
			end
			ST_FIND: begin
				if (sts.kind == KIND_COLLECT)
					state_d = ST_SCAN;
				else if (sts.full)
					state_d = ST_DONE;
				else if (sts.find_done)
					state_d = ST_PUT;
				else
					state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				state_d = sts.shift_done ? ST_PUT : ST_FIND;
			end
			ST_PUT: state_d = ST_DONE;
			ST_SCAN: begin
				if (!pend_q && sts.scan_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_busy)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		res_load  = 1'b0;
		res_has   = 1'b0;
		res_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !out_busy;
				cmd.load = in_valid && !out_busy;
			end
			ST_FIND: begin
				cmd.find_step = (sts.kind == KIND_SCHEDULE) && !sts.full &&
					!sts.find_done;
			end
			ST_SHIFT: cmd.shift_step = !sts.shift_done;
			ST_PUT: cmd.put = 1'b1;
			ST_SCAN: begin
				if (pend_q) begin
					if (!emit_blocked) begin
						cmd.scan_eval = 1'b1;
						// another hit follows, so the held one is not last
						if (sts.hit && sts.any_hit) begin
							res_load = 1'b1;
							res_has  = 1'b1;
						end
					end
				end else if (!sts.scan_done) begin
					cmd.scan_read = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_busy) begin
					res_load     = 1'b1;
					cmd.done_fin = (sts.kind == KIND_COLLECT);
					res_has      = (sts.kind == KIND_COLLECT) && sts.any_hit;
					res_last     = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_read |=> pend_q) else $error("read data not marked");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !out_busy) else $error("output overwritten");

endmodule
